[rtl/core/formatted_binary_image_writer_top_macros.svh]
// assertion macros for the formatted binary image writer
// used by formatted_binary_image_writer_top, expects clk_i and rst_ni in scope
`ifndef FORMATTED_BINARY_IMAGE_WRITER_TOP_MACROS_SVH
`define FORMATTED_BINARY_IMAGE_WRITER_TOP_MACROS_SVH

// same-cycle implication
`define FBW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fbw assertion failed");

// next-cycle implication
`define FBW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fbw assertion failed");

`endif

[rtl/core/fbw_pkg.sv]
// shared types and constants of the formatted binary image writer
// no dependencies
`timescale 1ns / 1ps

package fbw_pkg;

  localparam int FillBurst  = 64;
  localparam int AddrBits   = 32;
  localparam int CntW       = $clog2(FillBurst + 16);
  localparam int JobqDepth  = 4;
  localparam int JobqPtrW   = $clog2(JobqDepth);
  localparam int JobqCntW   = $clog2(JobqDepth + 1);

  localparam logic [7:0] ArrowA     = 8'h08;
  localparam logic [7:0] ArrowB     = 8'h1C;
  localparam logic [7:0] ShortMagA  = 8'h2A;
  localparam logic [7:0] ShortMagB  = 8'h49;
  localparam logic [7:0] LongMagA   = 8'h3E;
  localparam logic [7:0] LongMagB   = 8'h6B;
  localparam logic [7:0] PadByte    = 8'hFF;

  typedef enum logic [1:0] {
    CmdHeader  = 2'd0,
    CmdData    = 2'd1,
    CmdFill    = 2'd2,
    CmdTrailer = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusNoSize    = 2'd1,
    StatusPastBound = 2'd2,
    StatusMismatch  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    JobHeader,
    JobData,
    JobFill,
    JobTrailer,
    JobError
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic [31:0]       value;
    logic [CntW-1:0]   count;
    logic              pending;
    status_e           status;
  } job_t;

endpackage

[rtl/core/fbw_front.sv]
// front part: accepts items, keeps address, checksum and error state, builds jobs
// depends on fbw_pkg
`timescale 1ns / 1ps

module fbw_front import fbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_size_i,
  input  logic        accept_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] target_address_i,
  input  logic [7:0]  data_byte_i,
  output logic        job_valid_o,
  output job_t        job_o
);

  logic [31:0]         size_q;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [15:0]         sum_q, sum_d;
  status_e             failed_q, failed_d;

  logic [31:0]         addr_ext;
  logic [AddrBits-1:0] target;
  logic [AddrBits-1:0] diff;
  logic                burst_cap;
  logic [CntW-1:0]     fill_cnt;

  always_comb begin
    addr_ext  = 32'(addr_q);
    target    = AddrBits'(target_address_i);
    diff      = target - addr_q;
    burst_cap = diff > AddrBits'(FillBurst);
    fill_cnt  = burst_cap ? CntW'(FillBurst) : CntW'(diff);
  end

  always_comb begin
    addr_d      = addr_q;
    sum_d       = sum_q;
    failed_d    = failed_q;
    job_valid_o = 1'b1;
    job_o       = '{kind: JobError, value: 32'd0, count: CntW'(1), pending: 1'b0,
                    status: failed_q};
    if (failed_q == StatusOk) begin
      case (cmd_e'(command_i))
        CmdHeader: begin
          if (size_q == 32'd0) begin
            failed_d     = StatusNoSize;
            job_o.status = StatusNoSize;
          end else begin
            job_o.kind  = JobHeader;
            job_o.value = size_q;
          end
        end
        CmdData: begin
          if (addr_ext >= size_q) begin
            failed_d     = StatusPastBound;
            job_o.status = StatusPastBound;
          end else begin
            sum_d       = sum_q + 16'(data_byte_i);
            addr_d      = addr_q + AddrBits'(1);
            job_o.kind  = JobData;
            job_o.value = 32'(data_byte_i);
          end
        end
        CmdFill: begin
          job_o.kind    = JobFill;
          job_o.count   = fill_cnt;
          job_o.pending = burst_cap;
          if (target > addr_q) begin
            addr_d = addr_q + AddrBits'(fill_cnt);
          end else begin
            job_valid_o = 1'b0;
          end
        end
        CmdTrailer: begin
          if (addr_ext != size_q) begin
            failed_d     = StatusMismatch;
            job_o.status = StatusMismatch;
          end else begin
            job_o.kind  = JobTrailer;
            job_o.value = 32'(sum_q);
          end
        end
        default: begin
          job_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= 32'd0;
      addr_q   <= '0;
      sum_q    <= 16'd0;
      failed_q <= StatusOk;
    end else begin
      if (accept_i) begin
        addr_q <= addr_d;
        sum_q  <= sum_d;
      end
      if (cfg_we_i) begin
        size_q <= cfg_size_i;
      end
      if (cfg_we_i && cfg_size_i == 32'd0 && failed_q == StatusOk) begin
        failed_q <= StatusNoSize;
      end else if (accept_i) begin
        failed_q <= failed_d;
      end
    end
  end

endmodule

[rtl/core/fbw_jobq.sv]
// short job queue between front and back
// depends on fbw_pkg
`timescale 1ns / 1ps

module fbw_jobq import fbw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t                slot_q [JobqDepth];
  logic [JobqPtrW-1:0] wr_q, rd_q;
  logic [JobqCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == JobqCntW'(JobqDepth);
  assign empty_o = cnt_q == '0;
  assign job_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + JobqPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + JobqPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + JobqCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - JobqCntW'(1);
      end
    end
  end

endmodule

[rtl/core/fbw_back.sv]
// back part: expands jobs into the result register as stream bytes, one per cycle
// unless a waiting result byte is not popped or no job is ready; depends on fbw_pkg
`timescale 1ns / 1ps

module fbw_back import fbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        jq_job_i,
  input  logic        jq_empty_i,
  output logic        jq_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic [1:0]  status_o,
  output logic        fill_pending_o
);

  job_t            job_q;
  logic            busy_q;
  logic [CntW-1:0] idx_q;
  logic            out_valid_q;

  logic            is_short;
  logic [CntW-1:0] len;
  logic            last;
  logic            adv;
  logic [7:0]      cur_byte;
  logic [2:0]      nib_pos;
  logic [2:0]      nib_idx;

  always_comb begin
    is_short = job_q.value[31:16] == 16'd0;
    nib_idx  = 3'(idx_q - CntW'(6));
    nib_pos  = is_short ? (3'd3 - nib_idx) : (3'd7 - nib_idx);
    case (job_q.kind)
      JobHeader:  len = is_short ? CntW'(11) : CntW'(15);
      JobFill:    len = job_q.count;
      JobTrailer: len = CntW'(4);
      default:    len = CntW'(1);
    endcase
    last = idx_q == len - CntW'(1);

    cur_byte = 8'h00;
    case (job_q.kind)
      JobHeader: begin
        if (idx_q == CntW'(0) || idx_q == CntW'(4)) begin
          cur_byte = ArrowA;
        end else if (idx_q == CntW'(1)) begin
          cur_byte = ArrowB;
        end else if (idx_q == CntW'(2)) begin
          cur_byte = is_short ? ShortMagA : LongMagA;
        end else if (idx_q == CntW'(3)) begin
          cur_byte = is_short ? ShortMagB : LongMagB;
        end else if (idx_q == CntW'(5)) begin
          cur_byte = 8'h00;
        end else if (last) begin
          cur_byte = PadByte;
        end else begin
          cur_byte = {4'h0, job_q.value[4*nib_pos +: 4]};
        end
      end
      JobData:    cur_byte = job_q.value[7:0];
      JobFill:    cur_byte = PadByte;
      JobTrailer: begin
        if (idx_q == CntW'(2)) begin
          cur_byte = job_q.value[15:8];
        end else if (idx_q == CntW'(3)) begin
          cur_byte = job_q.value[7:0];
        end
      end
      default:    cur_byte = 8'h00;
    endcase

    adv      = busy_q && (!out_valid_q || pop_i);
    jq_pop_o = (!busy_q || (adv && last)) && !jq_empty_i;
  end

  assign empty_o = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (jq_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (adv) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (jq_pop_o) begin
      job_q <= jq_job_i;
    end
    if (adv) begin
      out_byte_o     <= cur_byte;
      last_of_run_o  <= last;
      status_o       <= (job_q.kind == JobError) ? job_q.status : StatusOk;
      fill_pending_o <= (job_q.kind == JobFill) && job_q.pending;
    end
  end

endmodule

[rtl/core/formatted_binary_image_writer_top.sv]
// formatted binary image writer: top level joining front, job queue and back
// depends on fbw_pkg, fbw_front, fbw_jobq, fbw_back and the macros header
//
// usage:
//   write the image size on image_size_we_i / image_size_i while idle; zero flags an error
//   input side is a queue: an item is taken when push_i is high and full_o is low
//   result side is a queue: a byte waits while empty_o is low, taken with pop_i
//   every item is taken in the cycle offered while the four-entry job queue has room
//   results leave at one byte per cycle from the back sequencer while pop_i keeps up
//     and jobs wait; bytes per item: data 1, header 11 or 15, fill 1 to 64,
//     trailer 4, any error 1
//   path of an item: job queue slot, back job register, result register
//   a fill whose target is already reached gives no bytes
//   reset clears address, checksum, size and error state; queues come up empty
//   when pop_i stays low the result register holds, the back stops, and once the
//   job queue fills full_o rises and input stalls; nothing is lost or repeated
`timescale 1ns / 1ps
`include "formatted_binary_image_writer_top_macros.svh"

module formatted_binary_image_writer_top import fbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        image_size_we_i,
  input  logic [31:0] image_size_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] target_address_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic [1:0]  status_o,
  output logic        fill_pending_o
);

  logic accept;
  logic job_valid;
  job_t front_job;
  job_t queued_job;
  logic jq_empty;
  logic jq_pop;

  assign accept = push_i && !full_o;

  fbw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (image_size_we_i),
    .cfg_size_i       (image_size_i),
    .accept_i         (accept),
    .command_i        (command_i),
    .target_address_i (target_address_i),
    .data_byte_i      (data_byte_i),
    .job_valid_o      (job_valid),
    .job_o            (front_job)
  );

  fbw_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && job_valid),
    .job_i   (front_job),
    .pop_i   (jq_pop),
    .job_o   (queued_job),
    .full_o  (full_o),
    .empty_o (jq_empty)
  );

  fbw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .jq_job_i       (queued_job),
    .jq_empty_i     (jq_empty),
    .jq_pop_o       (jq_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .status_o       (status_o),
    .fill_pending_o (fill_pending_o)
  );

  `FBW_ASSERT_NOW(a_err_single, !empty_o && status_o != StatusOk, last_of_run_o && out_byte_o == 8'h00 && !fill_pending_o)
  `FBW_ASSERT_NOW(a_pending_pad, !empty_o && fill_pending_o, out_byte_o == PadByte && status_o == StatusOk)
  `FBW_ASSERT_NEXT(a_err_sticky, !empty_o && pop_i && status_o != StatusOk, empty_o || status_o == $past(status_o))

endmodule

[tb/formatted_binary_image_writer_top_test.sv]
`timescale 1ns / 1ps
// testbench for formatted_binary_image_writer_top: a queue-fed item driver, a byte monitor
// and a behavioral model of the formatted binary stream; depends on fbw_pkg and the rtl

module formatted_binary_image_writer_top_test;
  import fbw_pkg::*;

  localparam int unsigned RunLimit = 1000000;
  localparam int RandomItems = 180;
  localparam int SettleCycles = 10;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] target_address;
    logic [7:0]  data_byte;
  } image_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    status_e    status;
    logic       fill_pending;
  } stream_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        image_size_we_i;
  logic [31:0] image_size_i;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [1:0]  command_i = CmdHeader;
  logic [31:0] target_address_i = 32'd0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_of_run_o;
  logic [1:0]  status_o;
  logic        fill_pending_o;

  formatted_binary_image_writer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .image_size_we_i (image_size_we_i),
    .image_size_i    (image_size_i),
    .push_i          (push_i),
    .full_o          (full_o),
    .command_i       (command_i),
    .target_address_i(target_address_i),
    .data_byte_i     (data_byte_i),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .status_o        (status_o),
    .fill_pending_o  (fill_pending_o)
  );

  // stream model state
  logic [31:0]  img_size = 32'd0;
  logic [31:0]  next_addr = 32'd0;
  logic [15:0]  byte_sum = 16'd0;
  status_e      sticky_status = StatusOk;
  logic [7:0]   run_bytes[$];
  stream_byte_t expected_stream[$];
  image_item_t  item_backlog[$];

  int          send_idle_pct;
  int          recv_idle_pct;
  logic        took_item = 1'b0;
  int          items_queued;
  int          items_taken = 0;
  int          bytes_checked = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic void close_run(input logic pending);
    stream_byte_t b;
    foreach (run_bytes[i]) begin
      b.out_byte = run_bytes[i];
      b.last_of_run = (i == run_bytes.size() - 1);
      b.status = StatusOk;
      b.fill_pending = pending;
      expected_stream.push_back(b);
    end
    run_bytes.delete();
  endfunction

  function automatic void flag_error(input status_e code);
    stream_byte_t b;
    if (sticky_status == StatusOk) sticky_status = code;
    b.out_byte = 8'h00;
    b.last_of_run = 1'b1;
    b.status = sticky_status;
    b.fill_pending = 1'b0;
    expected_stream.push_back(b);
  endfunction

  function automatic void predict_bytes(input cmd_e command, input logic [31:0] target,
                                        input logic [7:0] data);
    int burst;
    int i;
    if (sticky_status != StatusOk) begin
      flag_error(sticky_status);
      return;
    end
    case (command)
      CmdHeader: begin
        if (img_size == 32'd0) begin
          flag_error(StatusNoSize);
        end else begin
          run_bytes.push_back(ArrowA);
          run_bytes.push_back(ArrowB);
          if (img_size < 32'h0001_0000) begin
            run_bytes.push_back(ShortMagA);
            run_bytes.push_back(ShortMagB);
            run_bytes.push_back(ArrowA);
            run_bytes.push_back(8'h00);
            for (i = 3; i >= 0; i--) run_bytes.push_back({4'h0, img_size[4*i +: 4]});
          end else begin
            run_bytes.push_back(LongMagA);
            run_bytes.push_back(LongMagB);
            run_bytes.push_back(ArrowA);
            run_bytes.push_back(8'h00);
            for (i = 7; i >= 0; i--) run_bytes.push_back({4'h0, img_size[4*i +: 4]});
          end
          run_bytes.push_back(PadByte);
          close_run(1'b0);
        end
      end
      CmdData: begin
        if (next_addr >= img_size) begin
          flag_error(StatusPastBound);
        end else begin
          byte_sum = byte_sum + {8'h00, data};
          next_addr = next_addr + 32'd1;
          run_bytes.push_back(data);
          close_run(1'b0);
        end
      end
      CmdFill: begin
        burst = 0;
        while (next_addr < target && burst < FillBurst) begin
          next_addr = next_addr + 32'd1;
          burst++;
          run_bytes.push_back(PadByte);
        end
        close_run(next_addr < target);
      end
      default: begin
        if (next_addr != img_size) begin
          flag_error(StatusMismatch);
        end else begin
          run_bytes.push_back(8'h00);
          run_bytes.push_back(8'h00);
          run_bytes.push_back(byte_sum[15:8]);
          run_bytes.push_back(byte_sum[7:0]);
          close_run(1'b0);
        end
      end
    endcase
  endfunction

  task automatic queue_item(input cmd_e command, input logic [31:0] target,
                            input logic [7:0] data);
    image_item_t it;
    it.command = command;
    it.target_address = target;
    it.data_byte = data;
    item_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic write_size(input logic [31:0] value);
    @(negedge clk_i);
    image_size_we_i <= 1'b1;
    image_size_i <= value;
    @(negedge clk_i);
    image_size_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || expected_stream.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // item driver
  always @(negedge clk_i) begin : driver
    image_item_t drv_item;
    if (rst_ni && (!push_i || took_item)) begin
      if (item_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = item_backlog.pop_front();
        push_i <= 1'b1;
        command_i <= drv_item.command;
        target_address_i <= drv_item.target_address;
        data_byte_i <= drv_item.data_byte;
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pop_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: size writes and input handshake feed the model, output handshake is checked
  always @(posedge clk_i) begin : monitor
    stream_byte_t want;
    if (rst_ni && image_size_we_i) begin
      img_size = image_size_i;
      if (image_size_i == 32'd0 && sticky_status == StatusOk) sticky_status = StatusNoSize;
    end
    took_item = rst_ni && push_i && !full_o;
    if (took_item) begin
      predict_bytes(cmd_e'(command_i), target_address_i, data_byte_i);
      items_taken++;
    end
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_stream.size() == 0) begin
        $error("unexpected byte %0h with nothing expected", out_byte_o);
        mismatches++;
      end else begin
        want = expected_stream.pop_front();
        bytes_checked++;
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte_o);
          mismatches++;
        end
        if (last_of_run_o !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, last_of_run_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (fill_pending_o !== want.fill_pending) begin
          $error("fill_pending: expected %0b, got %0b", want.fill_pending, fill_pending_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == RunLimit) begin
      $display("formatted_binary_image_writer_top_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned addr;
    int unsigned len;
    int unsigned k;
    int unsigned pick;
    int random_done;
    rst_ni = 1'b0;
    image_size_we_i = 1'b0;
    image_size_i = 32'd0;
    items_queued = 0;
    send_idle_pct = 35;
    recv_idle_pct = 85;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: long header with all-ones size, extreme bytes, capped fill, reached fill
    write_size(32'hFFFF_FFFF);
    queue_item(CmdHeader, 32'd0, 8'd0);
    queue_item(CmdData, 32'd0, 8'h00);
    queue_item(CmdData, 32'hFFFF_FFFF, 8'hFF);
    queue_item(CmdFill, 32'hFFFF_FFFF, 8'h5A);
    queue_item(CmdFill, 32'd0, 8'h00);
    wait_drained();
    write_size(32'h0001_0000);
    queue_item(CmdHeader, 32'd0, 8'd0);
    wait_drained();
    write_size(32'h0000_FFFF);
    queue_item(CmdHeader, 32'd0, 8'd0);
    wait_drained();
    write_size(32'd1);
    queue_item(CmdHeader, 32'd0, 8'd0);
    wait_drained();
    // complete image with a fill split over two bursts
    addr = next_addr;
    write_size(addr + 66);
    queue_item(CmdHeader, 32'd0, 8'd0);
    queue_item(CmdFill, addr + 65, 8'd0);
    queue_item(CmdFill, addr + 65, 8'd0);
    queue_item(CmdFill, addr + 64, 8'd0);
    queue_item(CmdData, 32'd0, 8'hA5);
    queue_item(CmdTrailer, 32'd0, 8'd0);
    wait_drained();

    random_done = 0;
    while (random_done < RandomItems) begin
      if (random_done >= 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_done >= RandomItems / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 35;
      end
      addr = next_addr;
      if ($urandom_range(4) == 0) begin
        // open-ended image under a long-form bound
        write_size($urandom() | 32'h0001_0000);
        queue_item(CmdHeader, $urandom(), 8'($urandom()));
        random_done++;
        repeat ($urandom_range(1, 6)) begin
          queue_item(CmdData, $urandom(), 8'($urandom()));
          random_done++;
        end
        queue_item(CmdFill, $urandom(), 8'($urandom()));
        random_done++;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 30);
        write_size(addr + len);
        queue_item(CmdHeader, $urandom(), 8'($urandom()));
        random_done++;
        while (len > 0) begin
          pick = $urandom_range(9);
          if (pick < 5) begin
            queue_item(CmdData, $urandom(), 8'($urandom()));
            addr++;
            len--;
            random_done++;
          end else if (pick < 8) begin
            k = $urandom_range(1, len);
            repeat ((k + 63) / 64) begin
              queue_item(CmdFill, addr + k, 8'($urandom()));
              random_done++;
            end
            addr += k;
            len -= k;
          end else if (pick == 8) begin
            queue_item(CmdFill, $urandom_range(addr, 0), 8'($urandom()));
            random_done++;
          end else begin
            queue_item(CmdHeader, $urandom(), 8'($urandom()));
            random_done++;
          end
        end
        queue_item(CmdTrailer, $urandom(), 8'($urandom()));
        random_done++;
      end
      wait_drained();
    end

    // one sticky error per run, then every command once more
    addr = next_addr;
    pick = $urandom_range(1, 3);
    case (pick)
      1: write_size(32'd0);
      2: begin
        write_size(addr + 1);
        queue_item(CmdData, 32'd0, 8'($urandom()));
        queue_item(CmdData, 32'd0, 8'($urandom()));
      end
      default: begin
        write_size(addr + 2);
        queue_item(CmdHeader, 32'd0, 8'd0);
        queue_item(CmdFill, addr + 5, 8'd0);
        queue_item(CmdTrailer, 32'd0, 8'd0);
      end
    endcase
    queue_item(CmdHeader, 32'd0, 8'd0);
    queue_item(CmdData, 32'd0, 8'($urandom()));
    queue_item(CmdFill, addr + 9, 8'd0);
    queue_item(CmdTrailer, 32'd0, 8'd0);
    wait_drained();

    $display("covered %0d items and %0d stream bytes in %0d cycles", items_taken,
             bytes_checked, cycle_count);
    $display("both header forms, split fills, checksummed trailers, sticky error %s",
             sticky_status.name());
    if (mismatches == 0) begin
      $display("formatted_binary_image_writer_top_test: clean");
    end else begin
      $display("formatted_binary_image_writer_top_test: errors");
    end
    $finish;
  end

endmodule

[formatted_binary_image_writer_top.f]
+incdir+rtl/core
rtl/core/fbw_pkg.sv
rtl/core/fbw_front.sv
rtl/core/fbw_jobq.sv
rtl/core/fbw_back.sv
rtl/core/formatted_binary_image_writer_top.sv
tb/formatted_binary_image_writer_top_test.sv
